// ===== src/bcc_pkg.sv =====
// bcc_pkg: types and constants for the button click classifier
// used by button_click_classifier
// no dependencies
package bcc_pkg;

	localparam int TIMER_WIDTH_DEF = 16;
	localparam int CFG_DATA_W      = 16;
	localparam int CFG_ADDR_W      = 1;

	localparam logic [CFG_DATA_W-1:0] LONG_TICKS_RST = 16'd400;
	localparam logic [CFG_DATA_W-1:0] GAP_TICKS_RST  = 16'd20;

	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_LONG_TICKS = 1'd0,
		REG_GAP_TICKS  = 1'd1
	} cfg_reg_t;

	typedef enum logic [2:0] {
		PH_IDLE          = 3'd0,
		PH_FIRST_PRESS   = 3'd1,
		PH_FIRST_RELEASE = 3'd2,
		PH_SECOND_PRESS  = 3'd3,
		PH_LONG_PRESS    = 3'd4
	} phase_t;

	typedef enum logic [1:0] {
		EV_NONE   = 2'd0,
		EV_SINGLE = 2'd1,
		EV_DOUBLE = 2'd2,
		EV_LONG   = 2'd3
	} event_t;

endpackage

// ===== src/bcc_tick_if.sv =====
// bcc_tick_if: valid/ready channel carrying one button tick
// no dependencies
interface bcc_tick_if;
	logic valid;
	logic ready;
	logic pressed;

	modport source (output valid, output pressed, input ready);
	modport sink (input valid, input pressed, output ready);
endinterface

// ===== src/bcc_event_if.sv =====
// bcc_event_if: valid/ready channel carrying one click event
// no dependencies
interface bcc_event_if;
	logic       valid;
	logic       ready;
	logic [1:0] event_code;

	modport source (output valid, output event_code, input ready);
	modport sink (input valid, input event_code, output ready);
endinterface

// ===== src/button_click_classifier.sv =====
// button_click_classifier: single, double and long press detector
// depends on bcc_pkg, bcc_tick_if, bcc_event_if
//
// channel  dir  payload          width
// tick     in   pressed          1
// click    out  event_code       2
// cfg      in   cfg_we/addr/data 1/1/16
//
// one tick transfer gives one click transfer, through the input register, then the output register
// one tick per cycle sustained while click is not stalled: input register, then the phase
// machine and countdown decrement feed the output register combinationally
// output stall: one tick waits in the input register, then tick.ready drops
// arst_n clears phase, countdown, valids and loads the register defaults
module button_click_classifier #(
	parameter int TIMER_WIDTH = bcc_pkg::TIMER_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	bcc_tick_if.sink                       tick,
	bcc_event_if.source                    click,
	input  logic                           cfg_we,
	input  logic [bcc_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input  logic [bcc_pkg::CFG_DATA_W-1:0] cfg_data
);

	logic [bcc_pkg::CFG_DATA_W-1:0] long_ticks_q;
	logic [bcc_pkg::CFG_DATA_W-1:0] gap_ticks_q;

	logic                   valid_s1;
	logic                   pressed_s1;
	bcc_pkg::phase_t        phase_q, phase_d;
	logic [TIMER_WIDTH-1:0] count_q, count_d;
	logic [TIMER_WIDTH-1:0] count_dec;
	logic [TIMER_WIDTH-1:0] long_load, gap_load;
	logic                   expired;
	bcc_pkg::event_t        event_d;
	logic                   out_valid_q;
	bcc_pkg::event_t        out_event_q;
	logic                   adv;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_ticks_q <= bcc_pkg::LONG_TICKS_RST;
			gap_ticks_q  <= bcc_pkg::GAP_TICKS_RST;
		end else if (cfg_we) begin
			unique case (bcc_pkg::cfg_reg_t'(cfg_addr))
				bcc_pkg::REG_LONG_TICKS: long_ticks_q <= cfg_data;
				bcc_pkg::REG_GAP_TICKS:  gap_ticks_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// stage 1 moves into the output register when that is free or draining
	assign adv        = valid_s1 && (!out_valid_q || click.ready);
	assign tick.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (tick.ready) begin
			valid_s1 <= tick.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (tick.ready && tick.valid) begin
			pressed_s1 <= tick.pressed;
		end
	end

	assign long_load = TIMER_WIDTH'(long_ticks_q);
	assign gap_load  = TIMER_WIDTH'(gap_ticks_q);
	assign count_dec = count_q - TIMER_WIDTH'(1);
	assign expired   = (count_dec == '0);

	always_comb begin
		phase_d = phase_q;
		count_d = count_q;
		event_d = bcc_pkg::EV_NONE;
		unique case (phase_q)
			bcc_pkg::PH_IDLE: begin
				if (pressed_s1) begin
					phase_d = bcc_pkg::PH_FIRST_PRESS;
					count_d = long_load;
				end
			end
			bcc_pkg::PH_FIRST_PRESS: begin
				count_d = count_dec;
				if (expired) begin
					phase_d = bcc_pkg::PH_LONG_PRESS;
					event_d = bcc_pkg::EV_LONG;
				end else if (!pressed_s1) begin
					phase_d = bcc_pkg::PH_FIRST_RELEASE;
					count_d = gap_load;
				end
			end
			bcc_pkg::PH_FIRST_RELEASE: begin
				count_d = count_dec;
				if (expired) begin
					phase_d = bcc_pkg::PH_IDLE;
					event_d = bcc_pkg::EV_SINGLE;
				end else if (pressed_s1) begin
					phase_d = bcc_pkg::PH_SECOND_PRESS;
					count_d = long_load;
				end
			end
			bcc_pkg::PH_SECOND_PRESS: begin
				count_d = count_dec;
				if (expired) begin
					phase_d = bcc_pkg::PH_LONG_PRESS;
					event_d = bcc_pkg::EV_LONG;
				end else if (!pressed_s1) begin
					phase_d = bcc_pkg::PH_IDLE;
					event_d = bcc_pkg::EV_DOUBLE;
				end
			end
			bcc_pkg::PH_LONG_PRESS: begin
				if (!pressed_s1) begin
					phase_d = bcc_pkg::PH_IDLE;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= bcc_pkg::PH_IDLE;
			count_q <= '0;
		end else if (adv) begin
			phase_q <= phase_d;
			count_q <= count_d;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (click.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_event_q <= event_d;
		end
	end

	assign click.valid      = out_valid_q;
	assign click.event_code = out_event_q;

	a_hold_state: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(phase_q) && $stable(count_q))
		else $error("phase or countdown moved without a transfer into the output register");

	a_long_from_press: assert property (@(posedge clk) disable iff (!arst_n)
		adv && event_d == bcc_pkg::EV_LONG |=> phase_q == bcc_pkg::PH_LONG_PRESS)
		else $error("long press reported without entering the long press phase");

	a_press_loads: assert property (@(posedge clk) disable iff (!arst_n)
		adv && phase_q == bcc_pkg::PH_IDLE && pressed_s1
		|=> count_q == $past(long_load) && phase_q == bcc_pkg::PH_FIRST_PRESS)
		else $error("first press did not load the long press count");

	a_release_ends_long: assert property (@(posedge clk) disable iff (!arst_n)
		adv && phase_q == bcc_pkg::PH_LONG_PRESS && !pressed_s1 |=> phase_q == bcc_pkg::PH_IDLE)
		else $error("release in long press phase did not return to idle");

	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && out_valid_q && !click.ready |-> !tick.ready)
		else $error("tick accepted while both stages are held");

endmodule
